FILE: rtl/oal_pkg.sv
// Package for the ordered array list: field widths, request codes,
// controller states and the command and status bundles.
// No dependencies; every other file in the block but oal_ram uses it.
package oal_pkg;

    // Fixed widths of the request and response fields.
    localparam int ACT_W  = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;

    // Request codes carried in the action field.
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_WRITE,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request
        logic walk;      // step through the list, one entry per cycle
        logic final_wr;  // write the inserted value into its slot
        logic commit;    // update the length and load the response register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done; // no entry left to read, last read consumed this cycle
        logic hit;       // the entry under compare matches the search value
        logic ins_write; // an accepted insert still needs its value written
    } t_sts;

endpackage

FILE: rtl/oal_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on oal_pkg for the field widths.
interface oal_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [oal_pkg::ACT_W-1:0]            action;
    logic [oal_pkg::POS_W-1:0]            position;
    logic signed [oal_pkg::DATA_W-1:0]    item_value;

    modport source (output valid, action, position, item_value, input ready);
    modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface oal_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic signed [oal_pkg::DATA_W-1:0]    read_value;
    logic [oal_pkg::POS_W-1:0]            found_position;
    logic [oal_pkg::CNT_W-1:0]            count;

    modport source (output valid, ok, read_value, found_position, count, input ready);
    modport sink   (input valid, ok, read_value, found_position, count, output ready);
endinterface

FILE: rtl/oal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/oal_ctrl.sv
// Controller for the ordered array list: sequences one request at a time
// and owns the response valid flag. Depends on oal_pkg.
module oal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  oal_pkg::t_sts i_sts,
    output oal_pkg::t_cmd o_cmd
);
    import oal_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    // State and response flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (i_sts.hit || i_sts.walk_done) begin
                    n_state = i_sts.ins_write ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE: begin
                cmd.final_wr = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                // Wait until the response register is free.
                if (!r_out_valid || i_out_ready) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The response stays valid until it is taken or replaced.
    always_comb begin
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

FILE: rtl/oal_dp.sv
// Datapath for the ordered array list: element memory, length count,
// walk pointer, shift and compare logic, response register.
// Depends on oal_pkg and oal_ram.
module oal_dp #(
    parameter int CAPACITY = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oal_pkg::t_cmd                     i_cmd,
    output oal_pkg::t_sts                     o_sts,
    input  logic [oal_pkg::ACT_W-1:0]         i_action,
    input  logic [oal_pkg::POS_W-1:0]         i_position,
    input  logic signed [oal_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_ok,
    output logic signed [oal_pkg::DATA_W-1:0] o_read_value,
    output logic [oal_pkg::POS_W-1:0]         o_found_position,
    output logic [oal_pkg::CNT_W-1:0]         o_count
);
    import oal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Length and request registers.
    logic [CW-1:0]     r_count;
    logic [ACT_W-1:0]  r_act;
    logic [DATA_W-1:0] r_val;
    logic              r_valid;
    logic [AW-1:0]     r_pos_m1;
    logic              r_fwd;
    logic [CW-1:0]     r_p;
    logic [CW-1:0]     r_lim;

    // Walk pipeline and partial results.
    logic              r_rd_v;
    logic [AW-1:0]     r_rd_addr;
    logic              r_hit;
    logic [AW:0]       r_found;
    logic [DATA_W-1:0] r_rval;

    // Response register.
    logic              r_ok;
    logic [DATA_W-1:0] r_out_val;
    logic [POS_W-1:0]  r_out_found;
    logic [CNT_W-1:0]  r_out_count;

    // Request decode.
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     pm1_x;
    logic              pos_in_list;
    logic              ins_fit;
    logic              ld_valid;
    logic              ld_fwd;
    logic [CW-1:0]     ld_p;
    logic [CW-1:0]     ld_lim;

    // Walk and memory signals.
    logic [CW-1:0]     p_dec;
    logic [AW-1:0]     rd_addr;
    logic              issue;
    logic              pending;
    logic              first;
    logic              hit;
    logic              shift_wr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    logic [CW-1:0]     cnt_next;
    logic [XW-1:0]     cnt_next_x;
    logic [XW-1:0]     found_x;

    // Range checks and walk bounds for an incoming request.
    always_comb begin
        pos_x       = XW'(i_position);
        cnt_x       = XW'(r_count);
        pm1_x       = pos_x - XW'(1);
        pos_in_list = (pos_x != '0) && (pos_x <= cnt_x);
        ins_fit     = (r_count < CW'(CAPACITY)) && (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
        ld_valid    = 1'b0;
        ld_fwd      = 1'b1;
        ld_p        = '0;
        ld_lim      = '0;
        unique case (i_action)
            ACT_READ: begin
                ld_valid = pos_in_list;
                if (pos_in_list) begin
                    ld_p   = pm1_x[CW-1:0];
                    ld_lim = pos_x[CW-1:0];
                end
            end
            ACT_FIND: begin
                ld_valid = 1'b1;
                ld_lim   = r_count;
            end
            ACT_INSERT: begin
                // Walk down from the top, moving each entry up by one.
                ld_valid = ins_fit;
                ld_fwd   = 1'b0;
                if (ins_fit) begin
                    ld_p   = r_count;
                    ld_lim = pm1_x[CW-1:0];
                end
            end
            ACT_DELETE: begin
                // Read the removed entry, then move each later entry down.
                ld_valid = pos_in_list;
                if (pos_in_list) begin
                    ld_p   = pm1_x[CW-1:0];
                    ld_lim = r_count;
                end
            end
            ACT_CLEAR: begin
                ld_valid = 1'b1;
            end
            default: begin
                ld_valid = 1'b0;
            end
        endcase
    end

    // One read is issued in each walk cycle until the pointer reaches its limit; its data is used in the cycle after.
    always_comb begin
        p_dec    = r_p - CW'(1);
        rd_addr  = r_fwd ? r_p[AW-1:0] : p_dec[AW-1:0];
        issue    = i_cmd.walk && (r_p != r_lim);
        pending  = i_cmd.walk && r_rd_v;
        first    = (r_rd_addr == r_pos_m1);
        hit      = r_rd_v && (r_act == ACT_FIND) && (rdata == r_val);
        shift_wr = pending && r_valid &&
                   ((r_act == ACT_INSERT) || ((r_act == ACT_DELETE) && !first));
        we       = shift_wr || i_cmd.final_wr;
        if (i_cmd.final_wr) begin
            waddr = r_pos_m1;
            wdata = r_val;
        end else begin
            waddr = (r_act == ACT_INSERT) ? r_rd_addr + AW'(1) : r_rd_addr - AW'(1);
            wdata = rdata;
        end
    end

    // Element store.
    oal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // Length after the request.
    always_comb begin
        unique case (r_act)
            ACT_CLEAR:  cnt_next = '0;
            ACT_INSERT: cnt_next = r_valid ? r_count + CW'(1) : r_count;
            ACT_DELETE: cnt_next = r_valid ? r_count - CW'(1) : r_count;
            default:    cnt_next = r_count;
        endcase
        cnt_next_x = XW'(cnt_next);
        found_x    = XW'(r_found);
    end

    // Length count and read-valid flag, the registers here that reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= cnt_next;
            end
            r_rd_v <= issue;
        end
    end

    // Request capture, walk pointer and partial results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_val    <= i_item_value;
            r_valid  <= ld_valid;
            r_pos_m1 <= pm1_x[AW-1:0];
            r_fwd    <= ld_fwd;
            r_p      <= ld_p;
            r_lim    <= ld_lim;
            r_hit    <= 1'b0;
            r_found  <= '0;
            r_rval   <= '0;
        end else begin
            if (issue) begin
                r_p       <= r_fwd ? r_p + CW'(1) : p_dec;
                r_rd_addr <= rd_addr;
            end
            if (pending && hit) begin
                r_hit   <= 1'b1;
                r_found <= (AW + 1)'(r_rd_addr) + (AW + 1)'(1);
            end
            if (pending && r_valid && first &&
                ((r_act == ACT_READ) || (r_act == ACT_DELETE))) begin
                r_rval <= rdata;
            end
        end
    end

    // Response register, loaded once per request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok        <= r_valid && ((r_act != ACT_FIND) || r_hit);
            r_out_val   <= r_rval;
            r_out_found <= found_x[POS_W-1:0];
            r_out_count <= cnt_next_x[CNT_W-1:0];
        end
    end

    assign o_sts.walk_done  = (r_p == r_lim);
    assign o_sts.hit        = hit;
    assign o_sts.ins_write  = r_valid && (r_act == ACT_INSERT);
    assign o_ok             = r_ok;
    assign o_read_value     = r_out_val;
    assign o_found_position = r_out_found;
    assign o_count          = r_out_count;

endmodule

FILE: rtl/ordered_array_list.sv
// Ordered array list: one request at a time. The request is taken in idle, then the walk
// reads one entry per cycle from the single-read-port element RAM, an insert adds a write
// state, and the finish state loads the response once the response register is free.
// The next request is taken only after the controller is back in idle.
// Reset is synchronous: the list is empty, the response channel idle, RAM contents undefined.
module ordered_array_list #(
    parameter int CAPACITY = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oal_req_if.sink   i_req,
    oal_rsp_if.source o_rsp
);
    import oal_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Request sequencing.
    oal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage, walk and response payload.
    oal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_req.action),
        .i_position       (i_req.position),
        .i_item_value     (i_req.item_value),
        .o_ok             (o_rsp.ok),
        .o_read_value     (o_rsp.read_value),
        .o_found_position (o_rsp.found_position),
        .o_count          (o_rsp.count)
    );

endmodule
